### rtl/core/assert_macros.svh
// Assertion macros shared by the screening table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/core/sbst_pkg.sv
// Types, constants and helper functions of the Schwarz bound screening table.
package sbst_pkg;

    localparam int NUM_SHELLS  = 64;
    localparam int SHELL_W     = 8;
    localparam int VALUE_W     = 48;
    localparam int MAG_W       = 47;
    localparam int Q_W         = 24;
    localparam int THR_W       = 48;
    localparam int PROD_W      = 2 * Q_W;
    localparam int SQRT_STEPS  = (MAG_W + 1) / 2;
    localparam int TABLE_DEPTH = NUM_SHELLS * NUM_SHELLS;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [SHELL_W:0]     SHELL_LIMIT     = (SHELL_W + 1)'(NUM_SHELLS);
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = THR_W'(43);
    localparam logic [TABLE_AW-1:0]  SWEEP_LAST      = TABLE_AW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_AB,
        WR_BA,
        WR_SWEEP
    } wr_sel_t;

    typedef enum logic {
        RD_AB,
        RD_CD
    } rd_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SQRT,
        ST_WR_AB,
        ST_WR_BA,
        ST_QRD_CD,
        ST_QMUL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    latch_in;
        logic    max_update;
        logic    max_clear;
        logic    sqrt_start;
        rd_sel_t rd_sel;
        logic    qab_capture;
        logic    prod_capture;
        wr_sel_t wr_sel;
        logic    sweep_rst;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    last;
        logic    sqrt_busy;
        logic    sweep_done;
    } status_t;

    function automatic logic shell_in_range(input logic [SHELL_W-1:0] s);
        return {1'b0, s} < SHELL_LIMIT;
    endfunction

    // Only meaningful when both shells are in range.
    function automatic logic [TABLE_AW-1:0] table_index(input logic [SHELL_W-1:0] a,
                                                         input logic [SHELL_W-1:0] b);
        return TABLE_AW'(a) * TABLE_AW'(NUM_SHELLS) + TABLE_AW'(b);
    endfunction

endpackage

### rtl/core/schwarz_bound_screen_table.sv
// Top level of the Schwarz bound screening table.
// Load requests (action 0) stream the integral values of one diagonal shell-pair
// block; the request marked last adds an integer square root (one result bit per
// cycle in the root unit) and two table writes through the single write port.
// A query request reads Q(a,b) and Q(c,d) one after the other through the single
// read port and multiplies them. A clear request zeroes the 4096-entry table one
// entry per cycle, and the same clearing pass runs after reset, during which no
// request is taken (threshold writes always are). A finished result waits in an
// output register while the next request is taken.
module schwarz_bound_screen_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [sbst_pkg::SHELL_W-1:0] row_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] col_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] third_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] fourth_shell,
    input  logic [sbst_pkg::VALUE_W-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sbst_pkg::Q_W-1:0]     q_value,
    output logic                         significant,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbst_pkg::THR_W-1:0]   threshold
);
    import sbst_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sbst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    sbst_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .row_shell    (row_shell),
        .col_shell    (col_shell),
        .third_shell  (third_shell),
        .fourth_shell (fourth_shell),
        .value        (value),
        .last         (last),
        .cfg_we       (cfg_valid),
        .cfg_data     (threshold),
        .q_value      (q_value),
        .significant  (significant)
    );

endmodule

### rtl/core/sbst_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`include "assert_macros.svh"

module sbst_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sbst_pkg::MAG_W-1:0] operand,
    output logic                       busy,
    output logic [sbst_pkg::Q_W-1:0]   root
);
    import sbst_pkg::*;

    localparam logic [MAG_W-1:0] BIT_TOP = MAG_W'(1) << (2 * (SQRT_STEPS - 1));

    logic             busy_reg, busy_next;
    logic [MAG_W-1:0] x_reg, x_next;
    logic [MAG_W-1:0] res_reg, res_next;
    logic [MAG_W-1:0] bit_reg, bit_next;
    logic [MAG_W-1:0] trial;
    logic [MAG_W:0]   diff;

    // The partial root only has bits above the trial bit, so OR equals add.
    assign trial = res_reg | bit_reg;
    assign diff  = {1'b0, x_reg} - {1'b0, trial};

    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = operand;
            res_next  = '0;
            bit_next  = BIT_TOP;
        end
        else if (busy_reg)
        begin
            if (!diff[MAG_W])
            begin
                x_next   = diff[MAG_W-1:0];
                res_next = (res_reg >> 1) | bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[Q_W-1:0];

    // The remainder left over can never exceed twice the root.
    `ASSERT_ALWAYS(a_sqrt_remainder, $fell(busy_reg) |-> ({1'b0, x_reg} <= {res_reg, 1'b0}), "square root remainder too large")

endmodule

### rtl/core/sbst_dpath.sv
// Datapath: request registers, running maximum, Q table memory and query arithmetic.
module sbst_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbst_pkg::cmd_t               cmd,
    output sbst_pkg::status_t            status,
    input  logic [1:0]                   action,
    input  logic [sbst_pkg::SHELL_W-1:0] row_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] col_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] third_shell,
    input  logic [sbst_pkg::SHELL_W-1:0] fourth_shell,
    input  logic [sbst_pkg::VALUE_W-1:0] value,
    input  logic                         last,
    input  logic                         cfg_we,
    input  logic [sbst_pkg::THR_W-1:0]   cfg_data,
    output logic [sbst_pkg::Q_W-1:0]     q_value,
    output logic                         significant
);
    import sbst_pkg::*;

    action_t             action_reg;
    logic [SHELL_W-1:0]  row_reg, col_reg, third_reg, fourth_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                last_reg;

    logic [THR_W-1:0]    threshold_reg;
    logic [MAG_W-1:0]    max_reg, max_next;
    logic [MAG_W-1:0]    mag;
    logic [VALUE_W-1:0]  neg;

    logic [Q_W-1:0]      mem [TABLE_DEPTH];
    logic [Q_W-1:0]      rdata_reg;
    logic                rd_ok_reg;
    logic [TABLE_AW-1:0] raddr, waddr;
    logic [Q_W-1:0]      wdata;
    logic                we;
    logic [TABLE_AW-1:0] sweep_cnt_reg;

    logic [Q_W-1:0]      q_rd;
    logic [Q_W-1:0]      qab_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [Q_W-1:0]      q_value_reg;
    logic                significant_reg;
    logic                ab_ok, cd_ok;
    logic [Q_W-1:0]      root;
    logic                sqrt_busy;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg <= action_t'(action);
            row_reg    <= row_shell;
            col_reg    <= col_shell;
            third_reg  <= third_shell;
            fourth_reg <= fourth_shell;
            value_reg  <= value;
            last_reg   <= last;
        end
    end

    assign ab_ok = shell_in_range(row_reg) && shell_in_range(col_reg);
    assign cd_ok = shell_in_range(third_reg) && shell_in_range(fourth_reg);

    // The most negative value has magnitude 2^47, which saturates.
    assign neg = ~value_reg + VALUE_W'(1);

    always_comb
    begin
        if (value_reg[VALUE_W-1])
        begin
            mag = neg[VALUE_W-1] ? '1 : neg[MAG_W-1:0];
        end
        else
        begin
            mag = value_reg[MAG_W-1:0];
        end
        max_next = (mag > max_reg) ? mag : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            threshold_reg <= THRESHOLD_RESET;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.max_clear)
            begin
                max_reg <= '0;
            end
            else if (cmd.max_update)
            begin
                max_reg <= max_next;
            end
            if (cfg_we)
            begin
                threshold_reg <= cfg_data;
            end
            if (cmd.sweep_rst)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.wr_sel == WR_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + TABLE_AW'(1);
            end
        end
    end

    sbst_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (max_next),
        .busy    (sqrt_busy),
        .root    (root)
    );

    always_comb
    begin
        case (cmd.wr_sel)
            WR_AB:
            begin
                waddr = table_index(row_reg, col_reg);
                wdata = root;
                we    = ab_ok;
            end
            WR_BA:
            begin
                waddr = table_index(col_reg, row_reg);
                wdata = root;
                we    = ab_ok;
            end
            WR_SWEEP:
            begin
                waddr = sweep_cnt_reg;
                wdata = '0;
                we    = 1'b1;
            end
            default:
            begin
                waddr = sweep_cnt_reg;
                wdata = '0;
                we    = 1'b0;
            end
        endcase
        raddr = (cmd.rd_sel == RD_CD) ? table_index(third_reg, fourth_reg)
                                      : table_index(row_reg, col_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
        rd_ok_reg <= (cmd.rd_sel == RD_CD) ? cd_ok : ab_ok;
    end

    // An out-of-range pair reads as zero.
    assign q_rd = rd_ok_reg ? rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.qab_capture)
        begin
            qab_reg <= q_rd;
        end
        if (cmd.prod_capture)
        begin
            prod_reg <= qab_reg * q_rd;
        end
        if (cmd.out_load)
        begin
            if (action_reg == ACT_QUERY)
            begin
                q_value_reg     <= qab_reg;
                significant_reg <= (prod_reg >= threshold_reg);
            end
            else
            begin
                q_value_reg     <= ab_ok ? root : '0;
                significant_reg <= 1'b0;
            end
        end
    end

    assign q_value     = q_value_reg;
    assign significant = significant_reg;

    assign status.action     = action_reg;
    assign status.last       = last_reg;
    assign status.sqrt_busy  = sqrt_busy;
    assign status.sweep_done = (sweep_cnt_reg == SWEEP_LAST);

endmodule

### rtl/core/sbst_ctrl.sv
// Controller state machine: request sequencing, table sweep and result handshake.
`include "assert_macros.svh"

module sbst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sbst_pkg::cmd_t    cmd,
    input  sbst_pkg::status_t status
);
    import sbst_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_sel = WR_SWEEP;
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.action)
                    ACT_LOAD:
                    begin
                        cmd.max_update = 1'b1;
                        if (status.last)
                        begin
                            cmd.max_clear  = 1'b1;
                            cmd.sqrt_start = 1'b1;
                            state_next     = ST_SQRT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_QUERY:
                    begin
                        cmd.rd_sel = RD_AB;
                        state_next = ST_QRD_CD;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.sweep_rst = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = ST_WR_AB;
                end
            end
            ST_WR_AB:
            begin
                cmd.wr_sel = WR_AB;
                state_next = ST_WR_BA;
            end
            ST_WR_BA:
            begin
                cmd.wr_sel = WR_BA;
                state_next = ST_RESULT;
            end
            ST_QRD_CD:
            begin
                cmd.qab_capture = 1'b1;
                cmd.rd_sel      = RD_CD;
                state_next      = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.prod_capture = 1'b1;
                state_next       = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Reset starts with a sweep that zeroes the whole table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_ALWAYS(a_out_no_overwrite, cmd.out_load |-> (!out_valid_reg || out_ready), "pending result overwritten")
    `ASSERT_ALWAYS(a_sqrt_started, cmd.sqrt_start |=> status.sqrt_busy, "square root unit did not start")
    `ASSERT_NEVER(a_write_before_root, (state_reg == ST_WR_AB) && status.sqrt_busy, "table written before root is ready")

endmodule

### sim/tb.sv
// Self-checking testbench for the Schwarz bound screening table.
`timescale 1ns / 1ps

module tb;
    import sbst_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4400;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 2000000;

    localparam logic [VALUE_W-1:0] V_MOST_NEG = 48'h8000_0000_0000;
    localparam logic [VALUE_W-1:0] V_MAX_POS  = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] V_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] V_ONE      = 48'h0001_0000_0000;
    localparam logic [VALUE_W-1:0] V_NEG_TWO  = 48'hFFFE_0000_0000;

    typedef struct packed {
        action_t            act;
        logic [SHELL_W-1:0] ra;
        logic [SHELL_W-1:0] rb;
        logic [SHELL_W-1:0] rc;
        logic [SHELL_W-1:0] rd;
        logic [VALUE_W-1:0] v;
        logic               last;
    } screen_req_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           sig;
    } screen_res_t;

    typedef struct packed {
        screen_req_t req;
        logic        typed;
        screen_res_t res;
    } dir_row_t;

    localparam screen_res_t NO_RES = '0;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [1:0]           action       = '0;
    logic [SHELL_W-1:0]   row_shell    = '0;
    logic [SHELL_W-1:0]   col_shell    = '0;
    logic [SHELL_W-1:0]   third_shell  = '0;
    logic [SHELL_W-1:0]   fourth_shell = '0;
    logic [VALUE_W-1:0]   value        = '0;
    logic                 last         = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [Q_W-1:0]       q_value;
    logic                 significant;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [THR_W-1:0]     threshold    = '0;

    // Predictor state.
    logic [Q_W-1:0]       bound_tbl [TABLE_DEPTH];
    logic                 bound_set [TABLE_DEPTH];
    logic [MAG_W-1:0]     peak_mag;
    logic [THR_W-1:0]     screen_thr;

    screen_res_t          pending_results [$];
    dir_row_t             dir_rows [$];
    logic [SHELL_W-1:0]   hot_a [$];
    logic [SHELL_W-1:0]   hot_b [$];

    int                   mismatch_count  = 0;
    int                   results_checked = 0;
    int                   n_loads         = 0;
    int                   n_queries       = 0;
    int                   n_clears        = 0;
    int                   n_thr_writes    = 0;
    int                   tx_calm_left    = 0;
    int                   tx_burst_left   = 0;
    int                   cycle_count     = 0;
    logic                 rx_hold_go      = 1'b0;
    logic                 hold_taken      = 1'b0;

    schwarz_bound_screen_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .row_shell    (row_shell),
        .col_shell    (col_shell),
        .third_shell  (third_shell),
        .fourth_shell (fourth_shell),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .q_value      (q_value),
        .significant  (significant),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .threshold    (threshold)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("schwarz_bound_screen_table test failed");
            $finish;
        end
    end

    // Floor square root, one result bit per step from the top.
    function automatic logic [Q_W-1:0] floor_root(input logic [MAG_W-1:0] x);
        logic [Q_W-1:0]    root;
        logic [PROD_W-1:0] sq;
        root = '0;
        for (int i = Q_W - 1; i >= 0; i--)
        begin
            root[i] = 1'b1;
            sq = {{Q_W{1'b0}}, root} * {{Q_W{1'b0}}, root};
            if (sq > {1'b0, x})
                root[i] = 1'b0;
        end
        return root;
    endfunction

    function automatic logic [Q_W-1:0] bound_at(input logic [SHELL_W-1:0] a,
                                                input logic [SHELL_W-1:0] b);
        int idx;
        if (a >= NUM_SHELLS || b >= NUM_SHELLS)
            return '0;
        idx = a * NUM_SHELLS + b;
        return bound_set[idx] ? bound_tbl[idx] : '0;
    endfunction

    // Advances the predictor by one request; returns 1 when a result is due.
    function automatic logic screen_step(input screen_req_t r, output screen_res_t res);
        logic [VALUE_W-1:0] mag;
        logic [Q_W-1:0]     qa;
        logic [Q_W-1:0]     qb;
        logic [PROD_W-1:0]  prod;
        logic               emit;
        res  = '0;
        emit = 1'b0;
        case (r.act)
            ACT_LOAD:
            begin
                mag = r.v[VALUE_W-1] ? -r.v : r.v;
                // The most negative value has no positive twin and saturates.
                if (mag > {1'b0, {MAG_W{1'b1}}})
                    mag = {1'b0, {MAG_W{1'b1}}};
                if (mag[MAG_W-1:0] > peak_mag)
                    peak_mag = mag[MAG_W-1:0];
                if (r.last)
                begin
                    qa = floor_root(peak_mag);
                    peak_mag = '0;
                    if (r.ra < NUM_SHELLS && r.rb < NUM_SHELLS)
                    begin
                        bound_tbl[r.ra * NUM_SHELLS + r.rb] = qa;
                        bound_set[r.ra * NUM_SHELLS + r.rb] = 1'b1;
                        bound_tbl[r.rb * NUM_SHELLS + r.ra] = qa;
                        bound_set[r.rb * NUM_SHELLS + r.ra] = 1'b1;
                        res.q = qa;
                    end
                    emit = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                qa = bound_at(r.ra, r.rb);
                qb = bound_at(r.rc, r.rd);
                prod = {{Q_W{1'b0}}, qa} * {{Q_W{1'b0}}, qb};
                res.q = qa;
                res.sig = (prod >= screen_thr);
                emit = 1'b1;
            end
            ACT_CLEAR:
            begin
                foreach (bound_set[i])
                    bound_set[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return emit;
    endfunction

    function automatic screen_req_t make_req(input action_t act,
                                             input logic [SHELL_W-1:0] a,
                                             input logic [SHELL_W-1:0] b,
                                             input logic [SHELL_W-1:0] c,
                                             input logic [SHELL_W-1:0] d,
                                             input logic [VALUE_W-1:0] v,
                                             input logic l);
        screen_req_t r;
        r.act  = act;
        r.ra   = a;
        r.rb   = b;
        r.rc   = c;
        r.rd   = d;
        r.v    = v;
        r.last = l;
        return r;
    endfunction

    function automatic void add_row(input action_t act,
                                    input logic [SHELL_W-1:0] a,
                                    input logic [SHELL_W-1:0] b,
                                    input logic [SHELL_W-1:0] c,
                                    input logic [SHELL_W-1:0] d,
                                    input logic [VALUE_W-1:0] v,
                                    input logic l,
                                    input logic typed,
                                    input logic [Q_W-1:0] q,
                                    input logic sig);
        dir_row_t row;
        row.req   = make_req(act, a, b, c, d, v, l);
        row.typed = typed;
        row.res.q = q;
        row.res.sig = sig;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Small shells most of the time so that pairs get reloaded and queried.
    function automatic logic [SHELL_W-1:0] pick_shell();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return SHELL_W'($urandom_range(0, 15));
        if (pick < 85)
            return SHELL_W'($urandom_range(0, NUM_SHELLS - 1));
        return SHELL_W'($urandom_range(0, 255));
    endfunction

    function automatic void pick_pair(output logic [SHELL_W-1:0] a,
                                      output logic [SHELL_W-1:0] b);
        int idx;
        if (hot_a.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            idx = $urandom_range(0, hot_a.size() - 1);
            if ($urandom_range(0, 1))
            begin
                a = hot_a[idx];
                b = hot_b[idx];
            end
            else
            begin
                a = hot_b[idx];
                b = hot_a[idx];
            end
        end
        else
        begin
            a = pick_shell();
            b = pick_shell();
        end
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = V_MOST_NEG;
            1: v = V_MAX_POS;
            2: v = '0;
            default:
            begin
                v = VALUE_W'({$urandom, $urandom});
                v = v >> $urandom_range(0, VALUE_W - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic int next_gap();
        int pick;
        if (tx_burst_left > 0)
        begin
            tx_burst_left--;
            return 0;
        end
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            tx_calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Offers one request, waits for it to be taken, then records what it should produce.
    task automatic send_req(input screen_req_t r, input logic typed, input screen_res_t typed_res);
        screen_res_t res;
        int          gap;
        in_valid     <= 1'b1;
        action       <= r.act;
        row_shell    <= r.ra;
        col_shell    <= r.rb;
        third_shell  <= r.rc;
        fourth_shell <= r.rd;
        value        <= r.v;
        last         <= r.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (screen_step(r, res))
            pending_results.insert(pending_results.size(), typed ? typed_res : res);
        case (r.act)
            ACT_LOAD:  n_loads++;
            ACT_QUERY: n_queries++;
            ACT_CLEAR: n_clears++;
            default:
            begin
            end
        endcase
        if (r.act == ACT_LOAD && r.last && r.ra < NUM_SHELLS && r.rb < NUM_SHELLS)
        begin
            hot_a.insert(hot_a.size(), r.ra);
            hot_b.insert(hot_b.size(), r.rb);
            if (hot_a.size() > 32)
            begin
                void'(hot_a.pop_front());
                void'(hot_b.pop_front());
            end
        end
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets every expected result drain and any clearing pass finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_valid <= 1'b1;
        threshold <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        screen_thr = thr;
        n_thr_writes++;
    endtask

    task automatic run_random(input int target);
        int                 done_cnt;
        int                 pick;
        int                 n;
        logic [SHELL_W-1:0] a;
        logic [SHELL_W-1:0] b;
        logic [SHELL_W-1:0] c;
        logic [SHELL_W-1:0] d;
        done_cnt = 0;
        while (done_cnt < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // A well-formed diagonal block: one to six elements, the final one marked.
                a = pick_shell();
                b = pick_shell();
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_req(make_req(ACT_LOAD, a, b, SHELL_W'($urandom_range(0, 255)),
                                      SHELL_W'($urandom_range(0, 255)), rand_value(),
                                      i == n - 1), 1'b0, NO_RES);
                done_cnt += n;
            end
            else if (pick < 85)
            begin
                pick_pair(a, b);
                pick_pair(c, d);
                send_req(make_req(ACT_QUERY, a, b, c, d, rand_value(),
                                  1'($urandom_range(0, 1))), 1'b0, NO_RES);
                done_cnt++;
            end
            else if (pick < 92)
            begin
                send_req(make_req(ACT_LOAD, SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  rand_value(), 1'($urandom_range(0, 1))), 1'b0, NO_RES);
                done_cnt++;
            end
            else if (pick < 94)
            begin
                send_req(make_req(ACT_CLEAR, pick_shell(), pick_shell(), pick_shell(),
                                  pick_shell(), rand_value(), 1'($urandom_range(0, 1))),
                         1'b0, NO_RES);
                done_cnt++;
            end
            else if (pick < 97)
            begin
                send_req(make_req(ACT_QUERY, SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  SHELL_W'($urandom_range(0, 255)),
                                  rand_value(), 1'($urandom_range(0, 1))), 1'b0, NO_RES);
                done_cnt++;
            end
            else
            begin
                send_req(make_req(ACT_NOP, pick_shell(), pick_shell(), pick_shell(),
                                  pick_shell(), rand_value(), 1'($urandom_range(0, 1))),
                         1'b0, NO_RES);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        screen_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result with none expected: q_value=%0d significant=%0b",
                             q_value, significant);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (q_value !== want.q || significant !== want.sig)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: q_value exp %0d got %0d, significant exp %0b got %0b",
                                 want.q, q_value, want.sig, significant);
                end
            end
        end
    end

    initial
    begin : rx_pace
        int stall_left;
        int calm_left;
        int pick;
        stall_left = 0;
        calm_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_go && !hold_taken)
            begin
                // Long back-pressure so that the block fills up and stalls its input.
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    calm_left = $urandom_range(40, 200);
                else if (pick < 22)
                    stall_left = $urandom_range(1, 3);
                else if (pick < 25)
                    stall_left = $urandom_range(15, 60);
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : stimulus
        logic [THR_W-1:0] thr;
        int               ia;
        int               ib;
        foreach (bound_set[i])
        begin
            bound_set[i] = 1'b0;
            bound_tbl[i] = '0;
        end
        peak_mag   = '0;
        screen_thr = THRESHOLD_RESET;

        // Small roots 6 and 7 put the products 36, 42 and 49 on both sides of the
        // reset threshold.
        add_row(ACT_QUERY, 0, 0, 0, 0, '0, 1'b0, 1'b1, 0, 1'b0);
        add_row(ACT_LOAD, 3, 5, 0, 0, '0, 1'b1, 1'b1, 0, 1'b0);
        add_row(ACT_LOAD, 1, 1, 0, 0, 48'd36, 1'b1, 1'b1, 6, 1'b0);
        add_row(ACT_LOAD, 2, 2, 0, 0, 48'd49, 1'b1, 1'b1, 7, 1'b0);
        add_row(ACT_QUERY, 1, 1, 1, 1, '0, 1'b0, 1'b1, 6, 1'b0);
        add_row(ACT_QUERY, 1, 1, 2, 2, '0, 1'b0, 1'b1, 6, 1'b0);
        add_row(ACT_QUERY, 2, 2, 2, 2, '0, 1'b0, 1'b1, 7, 1'b1);
        add_row(ACT_LOAD, 3, 5, 0, 0, V_MOST_NEG, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 3, 5, 0, 0, 48'd1, 1'b1, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 63, 0, 0, 0, V_MAX_POS, 1'b1, 1'b0, 0, 1'b0);
        add_row(ACT_QUERY, 5, 3, 0, 63, '0, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 64, 2, 0, 0, 48'd1234, 1'b1, 1'b1, 0, 1'b0);
        add_row(ACT_LOAD, 255, 255, 255, 255, V_ALL_ONES, 1'b1, 1'b1, 0, 1'b0);
        add_row(ACT_QUERY, 64, 1, 1, 1, '0, 1'b0, 1'b1, 0, 1'b0);
        add_row(ACT_QUERY, 255, 255, 255, 255, V_ALL_ONES, 1'b1, 1'b1, 0, 1'b0);
        add_row(ACT_NOP, 255, 255, 255, 255, V_ALL_ONES, 1'b1, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 10, 20, 0, 0, V_ONE, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 10, 20, 0, 0, V_NEG_TWO, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD, 10, 20, 0, 0, 48'd5, 1'b1, 1'b0, 0, 1'b0);
        add_row(ACT_QUERY, 20, 10, 63, 0, '0, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_CLEAR, 0, 0, 0, 0, '0, 1'b0, 1'b0, 0, 1'b0);
        add_row(ACT_QUERY, 5, 3, 2, 2, '0, 1'b0, 1'b1, 0, 1'b0);
        add_row(ACT_LOAD, 0, 63, 0, 0, V_MAX_POS, 1'b1, 1'b0, 0, 1'b0);
        add_row(ACT_QUERY, 63, 0, 0, 63, '0, 1'b0, 1'b0, 0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        run_random(180);

        for (int phase = 1; phase <= 4; phase++)
        begin
            settle();
            case (phase)
                1: thr = '0;
                2: thr = {THR_W{1'b1}};
                3:
                begin
                    // Set the threshold to a product that stored pairs actually give.
                    ia = $urandom_range(0, hot_a.size() - 1);
                    ib = $urandom_range(0, hot_a.size() - 1);
                    thr = {{Q_W{1'b0}}, bound_at(hot_a[ia], hot_b[ia])} *
                          {{Q_W{1'b0}}, bound_at(hot_a[ib], hot_b[ib])};
                end
                default: thr = THR_W'({$urandom, $urandom}) >> $urandom_range(0, THR_W - 1);
            endcase
            write_threshold(thr);
            if (phase == 2)
            begin
                rx_hold_go <= 1'b1;
                tx_burst_left = 200;
            end
            run_random(200);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d loads, %0d queries, %0d clears and %0d threshold writes.",
                 n_loads, n_queries, n_clears, n_thr_writes);
        $display("%0d results compared, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("schwarz_bound_screen_table test passed");
        else
            $display("schwarz_bound_screen_table test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sbst_pkg.sv
rtl/core/sbst_isqrt.sv
rtl/core/sbst_dpath.sv
rtl/core/sbst_ctrl.sv
rtl/core/schwarz_bound_screen_table.sv
sim/tb.sv
